// ===== rtl/tss_pkg.sv =====
// Package for the tridiagonal system solver: sizes, fixed-point helpers, sequencer states.
// No dependencies.
package tss_pkg;

    localparam int MaxRows  = 64;
    localparam int FracBits = 16;
    localparam int IdxW     = $clog2(MaxRows);
    localparam int DivSteps = 32 + FracBits + 1;
    localparam int DcntW    = $clog2(DivSteps + 1);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RD,
        ST_MUL_R,
        ST_MUL_P,
        ST_NUM,
        ST_DIV_SUP,
        ST_DIV_NUM,
        ST_OUT,
        ST_BACK_MUL,
        ST_BACK_SUB
    } state_t;

    typedef struct packed {
        logic [31:0] value;
        logic        sat;
    } sat_t;

    function automatic sat_t sat32(input logic signed [65:0] v);
        sat_t r;
        r.sat = 1'b0;
        r.value = v[31:0];
        if (v > 66'sd2147483647) begin
            r.sat = 1'b1;
            r.value = 32'h7fffffff;
        end else if (v < -66'sd2147483648) begin
            r.sat = 1'b1;
            r.value = 32'h80000000;
        end
        return r;
    endfunction

    // Rounded product (ties toward +infinity) of two Q values; exact product given.
    function automatic logic signed [65:0] qround(input logic signed [63:0] p);
        logic signed [65:0] t;
        t = {{2{p[63]}}, p} + (66'sd1 <<< (FracBits - 1));
        return t >>> FracBits;
    endfunction

endpackage

// ===== rtl/tss_divider.sv =====
// Restoring signed divider, one quotient bit per cycle, truncation toward zero.
// Depends on tss_pkg.
module tss_divider (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               start,
    input  logic signed [31:0] numer,
    input  logic signed [31:0] denom,
    output logic               done,
    output logic signed [65:0] quot
);

    localparam int NW = 32 + tss_pkg::FracBits;

    logic [NW-1:0]           n_reg, n_next;
    logic [32:0]             rem_reg, rem_next;
    logic [31:0]             d_reg, d_next;
    logic                    neg_reg, neg_next;
    logic [tss_pkg::DcntW-1:0] cnt_reg, cnt_next;
    logic                    busy_reg, busy_next;
    logic [33:0]             trial;
    logic [32:0]             shifted;
    logic [31:0]             nmag;
    logic [NW-1:0]           q_bits;

    assign nmag = numer[31] ? 32'(-numer) : 32'(numer);

    always_comb begin
        n_next    = n_reg;
        rem_next  = rem_reg;
        d_next    = d_reg;
        neg_next  = neg_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        shifted   = {rem_reg[31:0], n_reg[NW-1]};
        trial     = {1'b0, shifted} - {2'b0, d_reg};
        if (start) begin
            n_next    = {nmag, {tss_pkg::FracBits{1'b0}}};
            d_next    = denom[31] ? 32'(-denom) : 32'(denom);
            neg_next  = numer[31] ^ denom[31];
            rem_next  = '0;
            cnt_next  = tss_pkg::DcntW'(NW);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (!trial[33]) begin
                rem_next = trial[32:0];
                n_next   = {n_reg[NW-2:0], 1'b1};
            end else begin
                rem_next = shifted;
                n_next   = {n_reg[NW-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == tss_pkg::DcntW'(1)) busy_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
        n_reg   <= n_next;
        rem_reg <= rem_next;
        d_reg   <= d_next;
        neg_reg <= neg_next;
    end

    // The finished quotient comes from the last step, so a new start in the same cycle
    // does not disturb it.
    assign q_bits = {n_reg[NW-2:0], ~trial[33]};
    assign done   = busy_reg && (cnt_reg == tss_pkg::DcntW'(1));
    assign quot   = neg_reg ? -$signed({18'b0, q_bits}) : $signed({18'b0, q_bits});

endmodule

// ===== rtl/tridiagonal_system_solver.sv =====
// Top level of the tridiagonal system solver (Thomas algorithm, Q16.16).
// Depends on tss_pkg and tss_divider.
//
// Channel  | Direction | Ports
// s_       | in        | s_valid, s_ready, s_sub_diag, s_main_diag, s_super_diag,
//          |           | s_rhs_value, s_last_row
// m_       | out       | m_valid, m_ready, m_row_index, m_solution_value,
//          |           | m_final_result, m_not_dominant, m_arith_fault
//
// A row after the first is accepted in the idle state, then forms the two products through
// the one shared multiplier and runs two 48-step divisions through the shared bit-serial
// divider, so a new row is taken only after both divisions of the previous one are done.
// The first row skips the products; a last row needs only the second division and then
// back-substitutes, one element at a time while m_ready is high.
// Reset clears the sticky flags, the row count and the held solution; the stores are not
// cleared. A stall on the result channel holds the sequencer in its output state.
module tridiagonal_system_solver (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic signed [31:0] s_sub_diag,
    input  logic signed [31:0] s_main_diag,
    input  logic signed [31:0] s_super_diag,
    input  logic signed [31:0] s_rhs_value,
    input  logic               s_last_row,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [5:0]         m_row_index,
    output logic signed [31:0] m_solution_value,
    output logic               m_final_result,
    output logic               m_not_dominant,
    output logic               m_arith_fault
);

    localparam int IW = tss_pkg::IdxW;

    // The two stores, read with a registered port.
    logic [31:0] ratio_mem   [tss_pkg::MaxRows];
    logic [31:0] partial_mem [tss_pkg::MaxRows];
    logic [31:0] ratio_rd_reg, partial_rd_reg;
    logic        wr_ratio, wr_partial;
    logic [IW-1:0] wr_addr, rd_addr;
    logic [31:0] wr_data;

    tss_pkg::state_t state_reg, state_next;
    logic [IW:0]   count_reg, count_next;
    logic [IW-1:0] idx_reg, idx_next;
    logic          dom_reg, dom_next, fault_reg, fault_next, last_reg, last_next;
    logic signed [31:0] sub_reg, sub_next, mid_reg, mid_next, sup_reg, sup_next;
    logic signed [31:0] rhs_reg, rhs_next, den_reg, den_next, num_reg, num_next;
    logic signed [31:0] x_reg, x_next;
    logic signed [63:0] prod_reg, prod_next;

    // Shared multiplier operands and product.
    logic signed [31:0] mul_a, mul_b;
    logic signed [63:0] mul_p;
    logic               div_start, div_done;
    logic signed [31:0] div_n, div_d;
    logic signed [65:0] div_q;
    tss_pkg::sat_t      s1, s2, sq, sb;

    logic [IW-1:0] in_idx;
    logic          in_last;
    logic [32:0]   msub, mmid, msup;

    tss_divider u_div (
        .aclk   (aclk),
        .aresetn(aresetn),
        .start  (div_start),
        .numer  (div_n),
        .denom  (div_d),
        .done   (div_done),
        .quot   (div_q)
    );

    assign in_idx  = count_reg[IW] ? IW'(tss_pkg::MaxRows - 1) : count_reg[IW-1:0];
    assign in_last = s_last_row || (in_idx == IW'(tss_pkg::MaxRows - 1));

    always_comb begin
        msub = (in_idx == '0) ? 33'd0
             : (s_sub_diag[31] ? -{s_sub_diag[31], s_sub_diag} : {1'b0, s_sub_diag});
        mmid = s_main_diag[31] ? -{s_main_diag[31], s_main_diag} : {1'b0, s_main_diag};
        msup = in_last ? 33'd0
             : (s_super_diag[31] ? -{s_super_diag[31], s_super_diag} : {1'b0, s_super_diag});
    end

    assign mul_p = mul_a * mul_b;

    // Saturated differences: modified denominator, modified right-hand side and the
    // back-substituted element.
    assign s1 = tss_pkg::sat32(66'(mid_reg) - tss_pkg::qround(prod_reg));
    assign s2 = tss_pkg::sat32(66'(rhs_reg) - tss_pkg::qround(prod_reg));
    assign sb = tss_pkg::sat32(66'($signed(partial_rd_reg)) - tss_pkg::qround(prod_reg));
    assign sq = tss_pkg::sat32(div_q);

    always_comb begin
        state_next = state_reg;
        count_next = count_reg;
        idx_next   = idx_reg;
        dom_next   = dom_reg;
        fault_next = fault_reg;
        last_next  = last_reg;
        sub_next   = sub_reg;
        mid_next   = mid_reg;
        sup_next   = sup_reg;
        rhs_next   = rhs_reg;
        den_next   = den_reg;
        num_next   = num_reg;
        x_next     = x_reg;
        prod_next  = prod_reg;
        mul_a      = sub_reg;
        mul_b      = $signed(ratio_rd_reg);
        div_start  = 1'b0;
        div_n      = sup_reg;
        div_d      = den_reg;
        wr_ratio   = 1'b0;
        wr_partial = 1'b0;
        wr_addr    = idx_reg;
        wr_data    = sq.value;
        rd_addr    = idx_reg - 1'b1;
        s_ready    = 1'b0;
        m_valid    = 1'b0;
        unique case (state_reg)
            tss_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    idx_next  = in_idx;
                    last_next = in_last;
                    sub_next  = s_sub_diag;
                    mid_next  = s_main_diag;
                    sup_next  = in_last ? 32'sd0 : s_super_diag;
                    rhs_next  = s_rhs_value;
                    den_next  = s_main_diag;
                    num_next  = s_rhs_value;
                    if ({1'b0, msup} + {1'b0, msub} > {1'b0, mmid}) dom_next = 1'b1;
                    if (in_idx == '0) begin
                        // Row zero divides straight away by its own diagonal.
                        div_start = 1'b1;
                        div_d     = s_main_diag;
                        if (in_last) begin
                            div_n      = s_rhs_value;
                            state_next = tss_pkg::ST_DIV_NUM;
                        end else begin
                            div_n      = s_super_diag;
                            state_next = tss_pkg::ST_DIV_SUP;
                        end
                    end else begin
                        state_next = tss_pkg::ST_RD;
                    end
                end
            end
            tss_pkg::ST_RD: begin
                state_next = tss_pkg::ST_MUL_R;
            end
            tss_pkg::ST_MUL_R: begin
                prod_next  = mul_p;
                state_next = tss_pkg::ST_MUL_P;
            end
            tss_pkg::ST_MUL_P: begin
                den_next = s1.value;
                if (s1.sat) fault_next = 1'b1;
                mul_b      = $signed(partial_rd_reg);
                prod_next  = mul_p;
                state_next = tss_pkg::ST_NUM;
            end
            tss_pkg::ST_NUM: begin
                num_next = s2.value;
                if (s2.sat) fault_next = 1'b1;
                div_start = 1'b1;
                if (last_reg) begin
                    div_n      = s2.value;
                    state_next = tss_pkg::ST_DIV_NUM;
                end else begin
                    state_next = tss_pkg::ST_DIV_SUP;
                end
            end
            tss_pkg::ST_DIV_SUP: begin
                if (div_done) begin
                    wr_ratio = 1'b1;
                    if (den_reg == '0) begin
                        wr_data    = sup_reg[31] ? 32'h80000000 : 32'h7fffffff;
                        fault_next = 1'b1;
                    end else if (sq.sat) begin
                        fault_next = 1'b1;
                    end
                    div_start  = 1'b1;
                    div_n      = num_reg;
                    state_next = tss_pkg::ST_DIV_NUM;
                end
            end
            tss_pkg::ST_DIV_NUM: begin
                if (div_done) begin
                    wr_partial = 1'b1;
                    if (den_reg == '0) begin
                        wr_data    = num_reg[31] ? 32'h80000000 : 32'h7fffffff;
                        fault_next = 1'b1;
                    end else if (sq.sat) begin
                        fault_next = 1'b1;
                    end
                    if (last_reg) begin
                        x_next     = $signed(wr_data);
                        state_next = tss_pkg::ST_OUT;
                    end else begin
                        count_next = {1'b0, idx_reg} + 1'b1;
                        state_next = tss_pkg::ST_IDLE;
                    end
                end
            end
            tss_pkg::ST_OUT: begin
                m_valid = 1'b1;
                if (m_ready) begin
                    if (idx_reg == '0) begin
                        count_next = '0;
                        dom_next   = 1'b0;
                        fault_next = 1'b0;
                        state_next = tss_pkg::ST_IDLE;
                    end else begin
                        // The read address is already the next index.
                        idx_next   = idx_reg - 1'b1;
                        state_next = tss_pkg::ST_BACK_MUL;
                    end
                end
            end
            tss_pkg::ST_BACK_MUL: begin
                rd_addr    = idx_reg;
                mul_a      = $signed(ratio_rd_reg);
                mul_b      = x_reg;
                prod_next  = mul_p;
                state_next = tss_pkg::ST_BACK_SUB;
            end
            tss_pkg::ST_BACK_SUB: begin
                rd_addr = idx_reg;
                x_next  = sb.value;
                if (sb.sat) fault_next = 1'b1;
                state_next = tss_pkg::ST_OUT;
            end
            default: state_next = tss_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= tss_pkg::ST_IDLE;
            count_reg <= '0;
            dom_reg   <= 1'b0;
            fault_reg <= 1'b0;
            x_reg     <= '0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            dom_reg   <= dom_next;
            fault_reg <= fault_next;
            x_reg     <= x_next;
        end
        idx_reg  <= idx_next;
        last_reg <= last_next;
        sub_reg  <= sub_next;
        mid_reg  <= mid_next;
        sup_reg  <= sup_next;
        rhs_reg  <= rhs_next;
        den_reg  <= den_next;
        num_reg  <= num_next;
        prod_reg <= prod_next;
    end

    always_ff @(posedge aclk) begin
        if (wr_ratio) ratio_mem[wr_addr] <= wr_data;
        if (wr_partial) partial_mem[wr_addr] <= wr_data;
        ratio_rd_reg   <= ratio_mem[rd_addr];
        partial_rd_reg <= partial_mem[rd_addr];
    end

    assign m_row_index      = 6'(idx_reg);
    assign m_solution_value = x_reg;
    assign m_final_result   = (idx_reg == '0);
    assign m_not_dominant   = dom_reg;
    assign m_arith_fault    = fault_reg;

endmodule
